### hdl/swmp_pkg.sv
// Shared constants, opcodes and types for the square-wave melody player.
`default_nettype none
package swmp_pkg;

  localparam int TABLE_DEPTH      = 64;
  localparam int SLOT_W           = $clog2(TABLE_DEPTH);
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int OP_W             = 2;
  localparam int FREQ_W           = 15;
  localparam int LEN_W            = 24;
  localparam int HALF_W           = 19;
  localparam int HALF_MAX         = (1 << HALF_W) - 1;
  // divider: dividend is the tick rate, divisor is twice the frequency
  localparam int DVD_W            = $clog2(TICKS_PER_SECOND + 1);
  localparam int DVS_W            = FREQ_W + 1;
  localparam int DCNT_W           = $clog2(DVD_W + 1);
  localparam int ENTRY_W          = FREQ_W + LEN_W + 1;

  typedef logic [OP_W-1:0] opcode_t;
  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_WRITE = 2'd1;
  localparam opcode_t OP_START = 2'd2;
  localparam opcode_t OP_NOP   = 2'd3;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [LEN_W-1:0]  length;
    logic              is_end;
  } note_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### hdl/swmp_if.sv
// Valid/ready channel interfaces for note commands and player status.
`default_nettype none
interface swmp_in_if;
  logic                          valid;
  logic                          ready;
  logic [swmp_pkg::OP_W-1:0]     opcode;
  logic [5:0]                    note_slot;
  logic [swmp_pkg::FREQ_W-1:0]   note_frequency;
  logic [swmp_pkg::LEN_W-1:0]    note_length;
  logic                          note_is_end;

  modport source (output valid, opcode, note_slot, note_frequency, note_length, note_is_end,
                  input ready);
  modport sink   (input valid, opcode, note_slot, note_frequency, note_length, note_is_end,
                  output ready);
endinterface

interface swmp_out_if;
  logic       valid;
  logic       ready;
  logic       speaker_level;
  logic       is_playing;
  logic [5:0] current_position;

  modport source (output valid, speaker_level, is_playing, current_position, input ready);
  modport sink   (input valid, speaker_level, is_playing, current_position, output ready);
endinterface
`default_nettype wire

### hdl/swmp_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module swmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/swmp_div.sv
// Restoring divider: tick rate / divisor, one quotient bit per cycle.
`default_nettype none
module swmp_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [swmp_pkg::DVS_W-1:0]    divisor,
  output      swmp_pkg::div_stat_t           stat,
  output      logic [swmp_pkg::DVD_W-1:0]    quotient
);

  localparam int DVS_W  = swmp_pkg::DVS_W;
  localparam int DVD_W  = swmp_pkg::DVD_W;
  localparam int DCNT_W = swmp_pkg::DCNT_W;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              fits;

  // shift next dividend bit into the partial remainder, then trial subtract
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= DVD_W'(swmp_pkg::TICKS_PER_SECOND);
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

### hdl/square_wave_melody_player.sv
// Square-wave melody player: note table, playback sequencer and half-period divider.
//
// Input channel in_ch carries one command per transfer: a one-microsecond tick,
// a note-table write (slot, frequency in Hz, length in ticks, end mark), a
// start of playback from entry zero, or a no-op. Every command gives exactly one
// status transfer on out_ch: speaker level, playing flag and current note index,
// as they stand after the command.
//
// Writes, no-ops and ticks inside a note go from idle straight to the emit
// state, which loads the status into the output register. A start, or a tick
// that moves to the next note, reads the note RAM in the read and load states
// and runs the restoring divider for the half period, one quotient bit per
// cycle over 20 bits; an end mark or a silent entry skips the divider.
// in_ready is high only while the sequencer is idle, so one command is in
// flight at a time.
//
// A finished status waits in the output register; the next command is taken
// while it waits, and that command completes once out_ch takes the old one.
// Reset stops playback with the speaker low. The note table is not cleared:
// playing an entry that was never written gives undefined results.
`default_nettype none
module square_wave_melody_player (
  input  wire logic   clk,
  input  wire logic   rst_n,
  swmp_in_if.sink     in_ch,
  swmp_out_if.source  out_ch
);

  localparam int SLOT_W = swmp_pkg::SLOT_W;
  localparam int LEN_W  = swmp_pkg::LEN_W;
  localparam int HALF_W = swmp_pkg::HALF_W;
  localparam int DVD_W  = swmp_pkg::DVD_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state_r,      state_nxt;
  logic [SLOT_W-1:0] idx_r,        idx_nxt;
  logic              playing_r,    playing_nxt;
  logic [SLOT_W-1:0] pos_r,        pos_nxt;
  logic [LEN_W-1:0]  len_left_r,   len_left_nxt;
  logic [HALF_W-1:0] reload_r,     reload_nxt;
  logic [HALF_W-1:0] half_left_r,  half_left_nxt;
  logic              level_r,      level_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic              out_level_r;
  logic              out_playing_r;
  logic [SLOT_W-1:0] out_pos_r;
  logic              out_load;

  logic                in_fire;
  logic                ram_we;
  swmp_pkg::note_t     wr_note;
  swmp_pkg::note_t     rd_note;
  logic                div_start;
  swmp_pkg::div_stat_t div_stat;
  logic [DVD_W-1:0]    div_q;
  logic [HALF_W-1:0]   half_sat;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign wr_note.frequency = in_ch.note_frequency;
  assign wr_note.length    = in_ch.note_length;
  assign wr_note.is_end    = in_ch.note_is_end;
  assign ram_we = in_fire && (in_ch.opcode == swmp_pkg::OP_WRITE)
               && ({1'b0, in_ch.note_slot} < 7'(swmp_pkg::TABLE_DEPTH));

  swmp_ram #(
    .WIDTH (swmp_pkg::ENTRY_W),
    .DEPTH (swmp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.note_slot[SLOT_W-1:0]),
    .wdata (wr_note),
    .re    (state_r == ST_READ),
    .raddr (idx_r),
    .rdata (rd_note)
  );

  swmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  ({rd_note.frequency, 1'b0}),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // half period is clamped to at least one tick and to the counter range
  always_comb begin
    if (div_q == '0) begin
      half_sat = HALF_W'(1);
    end else if (div_q > DVD_W'(swmp_pkg::HALF_MAX)) begin
      half_sat = HALF_W'(swmp_pkg::HALF_MAX);
    end else begin
      half_sat = div_q[HALF_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    playing_nxt   = playing_r;
    pos_nxt       = pos_r;
    len_left_nxt  = len_left_r;
    reload_nxt    = reload_r;
    half_left_nxt = half_left_r;
    level_nxt     = level_r;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EMIT;
          unique case (in_ch.opcode)
            swmp_pkg::OP_TICK: begin
              if (playing_r) begin
                if (len_left_r <= LEN_W'(1)) begin
                  if (pos_r == SLOT_W'(swmp_pkg::TABLE_DEPTH - 1)) begin
                    // ran past the last entry
                    playing_nxt   = 1'b0;
                    level_nxt     = 1'b0;
                    reload_nxt    = '0;
                    half_left_nxt = '0;
                    len_left_nxt  = '0;
                  end else begin
                    idx_nxt   = pos_r + 1'b1;
                    state_nxt = ST_READ;
                  end
                end else begin
                  len_left_nxt = len_left_r - 1'b1;
                  if (reload_r != '0) begin
                    if (half_left_r <= HALF_W'(1)) begin
                      level_nxt     = !level_r;
                      half_left_nxt = reload_r;
                    end else begin
                      half_left_nxt = half_left_r - 1'b1;
                    end
                  end
                end
              end
            end
            swmp_pkg::OP_START: begin
              idx_nxt   = '0;
              state_nxt = ST_READ;
            end
            swmp_pkg::OP_WRITE: ;
            swmp_pkg::OP_NOP: ;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        pos_nxt   = idx_r;
        state_nxt = ST_EMIT;
        if (rd_note.is_end) begin
          playing_nxt   = 1'b0;
          level_nxt     = 1'b0;
          reload_nxt    = '0;
          half_left_nxt = '0;
          len_left_nxt  = '0;
        end else begin
          playing_nxt  = 1'b1;
          len_left_nxt = rd_note.length;
          if (rd_note.frequency == '0) begin
            reload_nxt    = '0;
            half_left_nxt = '0;
            level_nxt     = 1'b0;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          reload_nxt    = half_sat;
          half_left_nxt = half_sat;
          level_nxt     = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      playing_r   <= 1'b0;
      pos_r       <= '0;
      len_left_r  <= '0;
      reload_r    <= '0;
      half_left_r <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      playing_r   <= playing_nxt;
      pos_r       <= pos_nxt;
      len_left_r  <= len_left_nxt;
      reload_r    <= reload_nxt;
      half_left_r <= half_left_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (out_load) begin
      out_level_r   <= level_r;
      out_playing_r <= playing_r;
      out_pos_r     <= pos_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.speaker_level    = out_level_r;
  assign out_ch.is_playing       = out_playing_r;
  assign out_ch.current_position = 6'(out_pos_r);

endmodule
`default_nettype wire

### hdl/swmp_chk.sv
// Port-level checker for the melody player, bound to the top level.
`default_nettype none
module swmp_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_speaker_level,
  input wire logic       out_is_playing,
  input wire logic [5:0] out_current_position
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("status valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speaker_level)
      && $stable(out_is_playing) && $stable(out_current_position))
    else $error("stalled status changed");

  a_silent_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_speaker_level && !out_is_playing))
    else $error("speaker high while stopped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one in flight");

endmodule

bind square_wave_melody_player swmp_chk u_swmp_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_speaker_level    (out_ch.speaker_level),
  .out_is_playing       (out_ch.is_playing),
  .out_current_position (out_ch.current_position)
);
`default_nettype wire
